// File: design/prd_pkg.sv
// Package with the constants and types of the planar row decoder.
package prd_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_PLANES = 8;
  localparam int ROW_BYTES  = ((MAX_WIDTH + 15) / 16) * 2 * (MAX_PLANES + 1);
  localparam int ADDR_W     = $clog2(ROW_BYTES);
  localparam int FILL_W     = $clog2(ROW_BYTES + 1);
  localparam int GRP_W      = $clog2(MAX_WIDTH / 8 + 1);
  localparam int PL_W       = $clog2(MAX_PLANES + 1);

  localparam logic [2:0] REG_WIDTH    = 3'd0;
  localparam logic [2:0] REG_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_PLANES   = 3'd2;
  localparam logic [2:0] REG_COMPRESS = 3'd3;
  localparam logic [2:0] REG_MASK     = 3'd4;

  localparam logic [7:0] CTRL_NOP = 8'h80;

  typedef enum logic [1:0] {
    PH_CTRL   = 2'd0,
    PH_LIT    = 2'd1,
    PH_REPEAT = 2'd2,
    PH_BAD    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_EMIT_RD,
    ST_EMIT_ACC,
    ST_EMIT_OUT
  } state_t;

  // Effective geometry shared by the sequencer and the emitter.
  typedef struct packed {
    logic [9:0]        width;
    logic [10:0]       height;
    logic [PL_W-1:0]   planes;
    logic [FILL_W-1:0] plane_bytes;
    logic [FILL_W-1:0] row_len;
    logic [GRP_W-1:0]  groups;
  } geom_t;

endpackage

// File: design/prd_geom.sv
// Clamped image geometry and row length, registered from the configuration.
module prd_geom
  import prd_pkg::*;
(
  input  logic        clk,
  input  logic [9:0]  image_width,
  input  logic [10:0] image_height,
  input  logic [3:0]  plane_count,
  input  logic [1:0]  mask_mode,
  output geom_t       geom
);

  logic [9:0]        w;
  logic [10:0]       h;
  logic [PL_W-1:0]   p;
  logic [FILL_W-1:0] pb;
  logic [PL_W:0]     pm;
  logic [10:0]       wr;

  always_comb begin
    w = (image_width == '0) ? 10'd1 :
        (image_width > 10'(MAX_WIDTH)) ? 10'(MAX_WIDTH) : image_width;
    h = (image_height == '0) ? 11'd1 :
        (image_height > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : image_height;
    p = (plane_count == '0) ? PL_W'(1) :
        (plane_count > 4'(MAX_PLANES)) ? PL_W'(MAX_PLANES) : PL_W'(plane_count);
    wr = ({1'b0, w} + 11'd15) & ~11'd15;
    pb = FILL_W'(wr >> 3);
    pm = {1'b0, p} + ((mask_mode == 2'd1) ? (PL_W+1)'(1) : '0);
  end

  // Product registered for timing; user changes config only while idle, unenforced.
  always_ff @(posedge clk) begin
    geom.width       <= w;
    geom.height      <= h;
    geom.planes      <= p;
    geom.plane_bytes <= pb;
    geom.row_len     <= FILL_W'(pb * pm);
    geom.groups      <= GRP_W'((w + 10'd7) >> 3);
  end

endmodule

// File: design/prd_emit.sv
// Plane accumulator that gathers one bit from each plane into eight chunky pixels.
module prd_emit
  import prd_pkg::*;
(
  input  logic       clk,
  input  logic       clear,
  input  logic       load,
  input  logic [2:0] plane,
  input  logic [7:0] rd_data,
  output logic [7:0] pix [8]
);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      if (clear) begin
        pix[i] <= '0;
      end else if (load) begin
        pix[i][plane] <= rd_data[7-i];
      end
    end
  end

endmodule

// File: design/planar_row_decoder_rle.sv
// Top level of the planar row decoder with ByteRun1 unpacking.
//
// The block takes one body byte per beat, unpacks it when compression is on, and
// fills a 576-byte row store that is written at one address per cycle. A control
// byte is handled in the idle state alone, a literal or raw byte also passes
// through the fill state once, and a repeat byte stays in the fill state for
// each stored copy. When a row is complete the block walks the row store with
// one read port. For each group of eight pixels it reads and accumulates every
// plane in turn, then presents the result beat, held while the output stalls.
// The block is not ready for body bytes while a byte or a row is being worked on.
// A write lands in the configuration registers, then in the geometry registers.
module planar_row_decoder_rle
  import prd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  body_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  pixel_0,
  output logic [7:0]  pixel_1,
  output logic [7:0]  pixel_2,
  output logic [7:0]  pixel_3,
  output logic [7:0]  pixel_4,
  output logic [7:0]  pixel_5,
  output logic [7:0]  pixel_6,
  output logic [7:0]  pixel_7,
  output logic [3:0]  valid_count,
  output logic [9:0]  row_index,
  output logic        end_of_row,
  output logic        end_of_image
);

  // Configuration registers.
  logic [9:0]  image_width;
  logic [10:0] image_height;
  logic [3:0]  plane_count;
  logic        compression_on;
  logic [1:0]  mask_mode;
  geom_t       geom;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= 10'd1;
      image_height   <= 11'd1;
      plane_count    <= 4'd1;
      compression_on <= 1'b0;
      mask_mode      <= 2'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:    image_width    <= cfg_data[9:0];
        REG_HEIGHT:   image_height   <= cfg_data;
        REG_PLANES:   plane_count    <= cfg_data[3:0];
        REG_COMPRESS: compression_on <= cfg_data[0];
        REG_MASK:     mask_mode      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  prd_geom u_geom (
    .clk,
    .image_width,
    .image_height,
    .plane_count,
    .mask_mode,
    .geom
  );

  // Control state.
  state_t            state, state_next;
  phase_t            phase, phase_next;
  logic [7:0]        run_left, run_left_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [9:0]        cur_row, cur_row_next;
  logic [7:0]        byte_q;
  logic [8:0]        copies, copies_next;
  logic [GRP_W-1:0]  grp, grp_next;
  logic [2:0]        plane, plane_next;

  // Row store.
  logic [7:0]        mem [ROW_BYTES];
  logic              wr_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill[ADDR_W-1:0]] <= byte_q;
    end
    rd_data <= mem[rd_addr];
  end

  logic [FILL_W-1:0] fill_inc;
  logic              row_done;
  assign fill_inc = fill + FILL_W'(1);
  assign row_done = fill_inc >= geom.row_len;

  // The read address of plane p for the current group: p * plane_bytes + grp.
  always_comb begin
    rd_addr = ADDR_W'(FILL_W'(plane) * geom.plane_bytes + FILL_W'(grp));
  end

  logic       acc_clear, acc_load;
  logic [7:0] pix [8];
  logic       last_grp;
  assign last_grp = (GRP_W'(grp + GRP_W'(1)) == geom.groups);

  prd_emit u_emit (
    .clk,
    .clear   (acc_clear),
    .load    (acc_load),
    .plane,
    .rd_data,
    .pix
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= PH_CTRL;
      run_left <= '0;
      fill     <= '0;
      cur_row  <= '0;
      copies   <= '0;
      grp      <= '0;
      plane    <= '0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      run_left <= run_left_next;
      fill     <= fill_next;
      cur_row  <= cur_row_next;
      copies   <= copies_next;
      grp      <= grp_next;
      plane    <= plane_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= body_byte;
    end
  end

  logic [10:0] row_inc;
  assign row_inc = {1'b0, cur_row} + 11'd1;

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    run_left_next = run_left;
    fill_next     = fill;
    cur_row_next  = cur_row;
    copies_next   = copies;
    grp_next      = grp;
    plane_next    = plane;
    in_ready      = 1'b0;
    wr_en         = 1'b0;
    acc_clear     = 1'b0;
    acc_load      = 1'b0;
    out_valid     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // Decide how many copies of the byte get stored.
          copies_next = 9'd0;
          if (!compression_on) begin
            copies_next = 9'd1;
          end else if (phase == PH_LIT && run_left != '0) begin
            copies_next   = 9'd1;
            run_left_next = run_left - 8'd1;
            if (run_left == 8'd1) begin
              phase_next = PH_CTRL;
            end
          end else if (phase == PH_REPEAT) begin
            copies_next   = {1'b0, run_left};
            phase_next    = PH_CTRL;
            run_left_next = '0;
          end else if (body_byte < CTRL_NOP) begin
            phase_next    = PH_LIT;
            run_left_next = body_byte + 8'd1;
          end else if (body_byte == CTRL_NOP) begin
            phase_next    = PH_CTRL;
            run_left_next = '0;
          end else begin
            phase_next    = PH_REPEAT;
            run_left_next = 8'(9'd257 - {1'b0, body_byte});
          end
          if (copies_next != '0) begin
            state_next = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        wr_en       = 1'b1;
        copies_next = copies - 9'd1;
        if (row_done) begin
          fill_next     = '0;
          phase_next    = PH_CTRL;
          run_left_next = '0;
          grp_next      = '0;
          plane_next    = '0;
          acc_clear     = 1'b1;
          state_next    = ST_EMIT_RD;
        end else begin
          fill_next = fill_inc;
          if (copies == 9'd1) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_EMIT_RD: begin
        // Read address is presented this cycle; data lands next cycle.
        state_next = ST_EMIT_ACC;
      end
      ST_EMIT_ACC: begin
        acc_load = 1'b1;
        if (PL_W'(plane) + PL_W'(1) >= geom.planes) begin
          state_next = ST_EMIT_OUT;
        end else begin
          plane_next = plane + 3'd1;
          state_next = ST_EMIT_RD;
        end
      end
      ST_EMIT_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          plane_next = '0;
          acc_clear  = 1'b1;
          if (last_grp) begin
            cur_row_next = (row_inc >= geom.height) ? '0 : row_inc[9:0];
            state_next   = ST_IDLE;
          end else begin
            grp_next   = grp + GRP_W'(1);
            state_next = ST_EMIT_RD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Pixels past the row end read as zero.
  logic [10:0] left;
  assign left = {1'b0, geom.width} - {1'b0, grp, 3'b000};
  assign valid_count = (left > 11'd8) ? 4'd8 : left[3:0];

  always_comb begin
    pixel_0 = (valid_count > 4'd0) ? pix[0] : '0;
    pixel_1 = (valid_count > 4'd1) ? pix[1] : '0;
    pixel_2 = (valid_count > 4'd2) ? pix[2] : '0;
    pixel_3 = (valid_count > 4'd3) ? pix[3] : '0;
    pixel_4 = (valid_count > 4'd4) ? pix[4] : '0;
    pixel_5 = (valid_count > 4'd5) ? pix[5] : '0;
    pixel_6 = (valid_count > 4'd6) ? pix[6] : '0;
    pixel_7 = (valid_count > 4'd7) ? pix[7] : '0;
  end

  assign row_index    = cur_row;
  assign end_of_row   = last_grp;
  assign end_of_image = last_grp && (row_inc >= geom.height);

`ifndef SYNTHESIS
  // Body bytes are never taken while a row is being emitted.
  a_no_in_during_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input accepted during row emission");

  // A stalled result beat holds its row and group.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(row_index) && $stable(valid_count)))
    else $error("result beat changed while stalled");

  // The fill position is back to zero whenever a row starts emitting.
  a_fill_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fill == '0))
    else $error("fill position not cleared at row end");
`endif

endmodule

// File: sim/planar_row_decoder_rle_tb.sv
// Self-checking testbench for the planar row decoder with ByteRun1 unpacking.
//
// A queue of body bytes feeds a clocked driver. Every accepted beat goes through a
// local model of the row buffer and the ByteRun1 decoder. That model queues the
// pixel groups that the beat should produce. A clocked monitor then compares each
// result beat, field by field, with the oldest queued group. Registers are written
// only while the block is idle. The run covers a short directed part and then random
// rows with random content under several register settings, the extremes among them.
module planar_row_decoder_rle_tb;
  import prd_pkg::*;

  // Unused register indexes: a write there must be ignored.
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  // ByteRun1 control bytes used by the directed part.
  localparam logic [7:0] CTRL_LIT_MAX = 8'h7F;  // copy 128 literals
  localparam logic [7:0] CTRL_REP_MAX = 8'h81;  // repeat the next byte 128 times
  localparam logic [7:0] CTRL_REP_64  = 8'hC1;  // repeat the next byte 64 times
  localparam logic [7:0] CTRL_REP_TWO = 8'hFF;  // repeat the next byte twice
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 250;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [7:0] pix [8];
    logic [3:0] count;
    logic [9:0] row;
    logic       eor;
    logic       eoi;
  } pixel_group_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  body_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5, pixel_6, pixel_7;
  logic [3:0]  valid_count;
  logic [9:0]  row_index;
  logic        end_of_row;
  logic        end_of_image;

  planar_row_decoder_rle uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .body_byte(body_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_0(pixel_0), .pixel_1(pixel_1), .pixel_2(pixel_2), .pixel_3(pixel_3),
    .pixel_4(pixel_4), .pixel_5(pixel_5), .pixel_6(pixel_6), .pixel_7(pixel_7),
    .valid_count(valid_count), .row_index(row_index),
    .end_of_row(end_of_row), .end_of_image(end_of_image)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Stimulus and scoreboard storage.
  logic [7:0]   body_queue[$];
  pixel_group_t group_queue[$];
  int           error_count = 0;
  int           bytes_taken = 0;
  int           groups_seen = 0;
  int           rows_seen = 0;
  int           sender_idle_pct = 0;
  int           receiver_idle_pct = 0;
  int           hold_requests = 0;
  int           hold_served = 0;
  int           hold_left = 0;
  int           stall_cycles = 0;
  logic         beat_in = 1'b0;

  // Local copy of the decoder state and its register file.
  logic [7:0]  row_mem [ROW_BYTES];
  int          fill_pos = 0;
  phase_t      run_phase = PH_CTRL;
  int          run_left = 0;
  int          row_ptr = 0;
  logic [9:0]  reg_width = 10'd1;
  logic [10:0] reg_height = 11'd1;
  logic [3:0]  reg_planes = 4'd1;
  logic        reg_compress = 1'b0;
  logic [1:0]  reg_mask = 2'd0;

  function automatic int clamp_to(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int plane_stride();
    return ((clamp_to(reg_width, MAX_WIDTH) + 15) & ~15) >> 3;
  endfunction

  function automatic int bytes_per_row();
    return plane_stride() * (clamp_to(reg_planes, MAX_PLANES) + (reg_mask == 2'd1 ? 1 : 0));
  endfunction

  // Converts the finished planar row into chunky groups and queues them.
  function automatic void queue_row_groups();
    int w, h, planes, stride, groups, x;
    pixel_group_t grp;
    w = clamp_to(reg_width, MAX_WIDTH);
    h = clamp_to(reg_height, MAX_HEIGHT);
    planes = clamp_to(reg_planes, MAX_PLANES);
    stride = plane_stride();
    groups = (w + 7) / 8;
    for (int g = 0; g < groups; g++) begin
      for (int i = 0; i < 8; i++) begin
        x = g * 8 + i;
        grp.pix[i] = '0;
        if (x < w) begin
          for (int p = 0; p < planes; p++)
            grp.pix[i][p] = row_mem[p * stride + (x >> 3)][7 - (x & 7)];
        end
      end
      grp.count = (w - g * 8 > 8) ? 4'd8 : 4'(w - g * 8);
      grp.row = 10'(row_ptr);
      grp.eor = (g == groups - 1);
      grp.eoi = (g == groups - 1) && (row_ptr >= h - 1);
      group_queue.push_back(grp);
    end
    row_ptr = (row_ptr + 1 >= h) ? 0 : row_ptr + 1;
    rows_seen++;
  endfunction

  // Stores one decoded byte; a full row resets the decoder and queues its groups.
  function automatic bit store_byte(logic [7:0] b);
    if (fill_pos < ROW_BYTES) row_mem[fill_pos] = b;
    fill_pos++;
    if (fill_pos >= bytes_per_row()) begin
      fill_pos = 0;
      run_phase = PH_CTRL;
      run_left = 0;
      queue_row_groups();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void decode_body_byte(logic [7:0] b);
    bit full;
    int n;
    full = 1'b0;
    if (!reg_compress) begin
      full = store_byte(b);
    end else if (run_phase == PH_LIT && run_left != 0) begin
      run_left--;
      if (run_left == 0) run_phase = PH_CTRL;
      full = store_byte(b);
    end else if (run_phase == PH_REPEAT) begin
      n = run_left;
      run_phase = PH_CTRL;
      run_left = 0;
      while (n != 0 && !full) begin
        n--;
        full = store_byte(b);
      end
    end else if (b < CTRL_NOP) begin
      run_phase = PH_LIT;
      run_left = b + 1;
    end else if (b == CTRL_NOP) begin
      run_phase = PH_CTRL;
      run_left = 0;
    end else begin
      run_phase = PH_REPEAT;
      run_left = 257 - b;
    end
  endfunction

  // Register write: held until the block takes it, then mirrored locally.
  task automatic write_reg(input logic [2:0] idx, input int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 11'(val);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WIDTH:    reg_width = 10'(val);
      REG_HEIGHT:   reg_height = 11'(val);
      REG_PLANES:   reg_planes = 4'(val);
      REG_COMPRESS: reg_compress = 1'(val);
      REG_MASK:     reg_mask = 2'(val);
      default:      ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(input int w, input int h, input int p, input int c,
                              input int m);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_PLANES, p);
    write_reg(REG_COMPRESS, c);
    write_reg(REG_MASK, m);
  endtask

  // Waits for every queued byte and group, then lets a byte that makes no
  // result (a long repeat) finish before the registers change.
  task automatic drain();
    while (body_queue.size() != 0 || in_valid || group_queue.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Queues packed or raw rows of the current length with random content until
  // at least budget bytes are queued; now and then a stray byte breaks the sequence.
  task automatic queue_random_rows(input int budget);
    int made, need, k;
    logic [7:0] r;
    made = 0;
    while (made < budget) begin
      need = bytes_per_row();
      while (need > 0 && made < budget) begin
        if ($urandom_range(99) < 8) begin
          r = ($urandom_range(1) != 0) ? CTRL_NOP : 8'($urandom);
          body_queue.push_back(r);
          made++;
        end else if (!reg_compress) begin
          body_queue.push_back(8'($urandom));
          made++;
          need--;
        end else if ($urandom_range(1) != 0) begin
          k = $urandom_range(1, (need < 6) ? need + 1 : 6);
          body_queue.push_back(8'(k - 1));
          for (int i = 0; i < k; i++) body_queue.push_back(8'($urandom));
          made += k + 1;
          need -= k;
        end else begin
          k = $urandom_range(2, 128);
          body_queue.push_back(8'(257 - k));
          body_queue.push_back(8'($urandom));
          made += 2;
          need -= k;
        end
      end
    end
  endtask

  // Driver: a new beat is offered only once the current one has been taken.
  always @(negedge clk) begin
    if (!rst && (!in_valid || beat_in)) begin
      if (body_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_valid <= 1'b1;
        body_byte <= body_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off counted here.
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rst && ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Monitor: predicts from accepted body beats and checks result beats.
  always @(posedge clk) begin
    pixel_group_t want;
    logic [7:0] got [8];
    beat_in <= in_valid && in_ready && !rst;
    if (!rst) begin
      if (in_valid && in_ready) begin
        decode_body_byte(body_byte);
        bytes_taken++;
      end
      if (out_valid && out_ready) begin
        groups_seen++;
        if (group_queue.size() == 0) begin
          $error("result beat with no pixel group pending (row %0d)", row_index);
          error_count++;
        end else begin
          want = group_queue.pop_front();
          got = '{pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5, pixel_6, pixel_7};
          for (int i = 0; i < 8; i++) begin
            if (got[i] !== want.pix[i]) begin
              $error("pixel_%0d: expected %0d, got %0d", i, want.pix[i], got[i]);
              error_count++;
            end
          end
          if (valid_count !== want.count) begin
            $error("valid_count: expected %0d, got %0d", want.count, valid_count);
            error_count++;
          end
          if (row_index !== want.row) begin
            $error("row_index: expected %0d, got %0d", want.row, row_index);
            error_count++;
          end
          if (end_of_row !== want.eor) begin
            $error("end_of_row: expected %0d, got %0d", want.eor, end_of_row);
            error_count++;
          end
          if (end_of_image !== want.eoi) begin
            $error("end_of_image: expected %0d, got %0d", want.eoi, end_of_image);
            error_count++;
          end
        end
      end
      // Watchdog: any beat on any channel counts as progress.
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("planar_row_decoder_rle_tb: errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    sender_idle_pct = 22;
    receiver_idle_pct = 58;

    // Reset geometry: one pixel, one plane, raw, so every two bytes make a row,
    // and the single-row image wraps each time.
    body_queue = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    drain();

    // Packed rows of 20 pixels, three planes and a mask plane (16 bytes a row):
    // a no-op control byte, a short literal, a repeat of two, and a long repeat
    // that is cut off at the row end.
    set_geometry(20, 2, 3, 1, 1);
    body_queue = '{CTRL_NOP, 8'h02, 8'hA5, 8'h3C, 8'hF0, CTRL_REP_TWO, 8'h5A,
                   CTRL_REP_MAX, 8'hC3};
    drain();

    // One plane, no mask (4 bytes a row): a 128-byte literal is cut off, so the
    // next byte is read as a control byte again; then a repeat is cut off.
    write_reg(REG_PLANES, 1);
    write_reg(REG_MASK, 0);
    body_queue = '{CTRL_LIT_MAX, 8'h01, 8'h80, 8'hFE, 8'h7F,
                   8'h01, 8'h81, 8'h18, CTRL_REP_TWO + 8'h00 - 8'h01, 8'hE7};
    drain();

    // Out-of-range registers saturate: 512 pixels, eight planes plus mask, the
    // full 576-byte row, built from four long repeats and one of 64.
    set_geometry(1023, 2047, 15, 1, 1);
    write_reg(REG_SPARE_LO, 11'h7FF);
    write_reg(REG_SPARE_HI, 0);
    for (int i = 0; i < 4; i++) begin
      body_queue.push_back(CTRL_REP_MAX);
      body_queue.push_back(8'($urandom));
    end
    body_queue.push_back(CTRL_REP_64);
    body_queue.push_back(8'($urandom));
    queue_random_rows(10);
    drain();

    // Zero values count as one; mask codes other than one mean no mask plane.
    // Rows are two bytes here, so while the receiver holds off the block fills
    // up and stalls its input with the sender still offering bytes.
    set_geometry(0, 0, 0, 0, 3);
    hold_requests = hold_requests + 1;
    queue_random_rows(6);
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      sender_idle_pct = (mode == 0) ? 22 : (mode == 1) ? 58 : 0;
      receiver_idle_pct = (mode == 0) ? 58 : (mode == 1) ? 22 : 0;
      for (int k = 0; k < 2; k++) begin
        set_geometry($urandom_range(1, 40), $urandom_range(1, 4), $urandom_range(1, 8),
                     $urandom_range(1), $urandom_range(3));
        queue_random_rows(12);
        drain();
      end
    end
    write_reg(REG_MASK, 2);

    $display("Covered %0d body bytes and %0d rows in %0d pixel groups, raw and packed,",
             bytes_taken, rows_seen, groups_seen);
    $display("from one pixel to 512 pixels per row and up to eight planes with mask.");
    if (group_queue.size() != 0) begin
      $error("%0d pixel groups never arrived", group_queue.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("planar_row_decoder_rle_tb: clean");
    end else begin
      $display("planar_row_decoder_rle_tb: errors");
    end
    $finish;
  end

endmodule
